// ----- hw/rtl/rc4_pkg.sv -----
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared widths, register indexes, micro-op codes and the control/status
// structs between the RC4 controller and datapath.
// ----------------------------------------------------------------------------
package rc4_pkg;

	localparam int IDX_W         = 8;
	localparam int PERM_SIZE     = 1 << IDX_W;
	localparam int KEY_BYTES_MAX = 16;
	localparam int KEY_IDX_W     = 4;
	localparam int KEY_LEN_W     = 5;
	localparam int CFG_W         = 64;
	localparam int CFG_IDX_W     = 2;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_LO  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HI  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN = 2'd2;

	localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd16;

	// table micro-ops issued by the controller, one per cycle except while idle or holding for the output
	localparam int OP_W = 4;
	typedef logic [OP_W-1:0] op_t;

	localparam op_t OP_NONE     = 4'd0;
	localparam op_t OP_KS_RD_N  = 4'd1;
	localparam op_t OP_KS_RD_J  = 4'd2;
	localparam op_t OP_KS_WR_N  = 4'd3;
	localparam op_t OP_KS_WR_J  = 4'd4;
	localparam op_t OP_PG_RD_I  = 4'd5;
	localparam op_t OP_PG_RD_J  = 4'd6;
	localparam op_t OP_PG_WR_I  = 4'd7;
	localparam op_t OP_PG_WR_J  = 4'd8;

	typedef struct packed {
		logic capture;   // latch the incoming data byte
		logic clr_valid; // table back to identity
		logic ks_init;   // zero key-schedule counters and both indices
		op_t  op;
		logic out_load;  // load output register
		logic out_hold;  // ... from the parked result rather than the live one
	} cmd_t;

	typedef struct packed {
		logic ks_last;   // key schedule on its final round
	} sts_t;

endpackage

// ----- hw/rtl/rc4_ctrl.sv -----
// ----------------------------------------------------------------------------
// rc4_ctrl
// Sequencer for the key schedule and keystream steps, plus the output
// request valid flag.
// ----------------------------------------------------------------------------
module rc4_ctrl import rc4_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_start,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd,
	input  sts_t sts
);

	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] ST_IDLE   = 4'd0;
	localparam logic [ST_W-1:0] ST_KS_RDN = 4'd1;
	localparam logic [ST_W-1:0] ST_KS_RDJ = 4'd2;
	localparam logic [ST_W-1:0] ST_KS_WRN = 4'd3;
	localparam logic [ST_W-1:0] ST_KS_WRJ = 4'd4;
	localparam logic [ST_W-1:0] ST_PG_RDI = 4'd5;
	localparam logic [ST_W-1:0] ST_PG_RDJ = 4'd6;
	localparam logic [ST_W-1:0] ST_PG_WRI = 4'd7;
	localparam logic [ST_W-1:0] ST_PG_WRJ = 4'd8;
	localparam logic [ST_W-1:0] ST_HOLD   = 4'd9;

	logic [ST_W-1:0] state_q, state_d;
	logic            out_valid_q;
	logic            slot_free;
	logic            accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.op  = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					if (in_start) begin
						cmd.clr_valid = 1'b1;
						cmd.ks_init   = 1'b1;
						state_d       = ST_KS_RDN;
					end else begin
						cmd.op  = OP_PG_RD_I;
						state_d = ST_PG_RDJ;
					end
				end
			end
			ST_KS_RDN: begin
				cmd.op  = OP_KS_RD_N;
				state_d = ST_KS_RDJ;
			end
			ST_KS_RDJ: begin
				cmd.op  = OP_KS_RD_J;
				state_d = ST_KS_WRN;
			end
			ST_KS_WRN: begin
				cmd.op  = OP_KS_WR_N;
				state_d = ST_KS_WRJ;
			end
			ST_KS_WRJ: begin
				cmd.op  = OP_KS_WR_J;
				state_d = sts.ks_last ? ST_PG_RDI : ST_KS_RDN;
			end
			ST_PG_RDI: begin
				cmd.op  = OP_PG_RD_I;
				state_d = ST_PG_RDJ;
			end
			ST_PG_RDJ: begin
				cmd.op  = OP_PG_RD_J;
				state_d = ST_PG_WRI;
			end
			ST_PG_WRI: begin
				cmd.op  = OP_PG_WR_I;
				state_d = ST_PG_WRJ;
			end
			ST_PG_WRJ: begin
				cmd.op = OP_PG_WR_J;
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					cmd.out_hold = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- hw/rtl/rc4_dp.sv -----
// ----------------------------------------------------------------------------
// rc4_dp
// Permutation table (single write, single registered read), indices,
// key registers and the output byte register.
// ----------------------------------------------------------------------------
module rc4_dp import rc4_pkg::*; #(
	parameter int MAX_KEY_BYTES = KEY_BYTES_MAX
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [IDX_W-1:0]     in_byte,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	output logic [IDX_W-1:0]     out_byte
);

	logic [IDX_W-1:0]     mem_q [PERM_SIZE];
	logic [PERM_SIZE-1:0] vld_q;
	logic [IDX_W-1:0]     rd_data_q, rd_addr_q;
	logic                 rd_vld_q;

	logic [CFG_W-1:0]     key_lo_q, key_hi_q;
	logic [KEY_LEN_W-1:0] key_len_q;

	logic [IDX_W-1:0]     i_q, j_q, n_q, mix_q, si_q, sj_q, data_q, res_q, out_q;
	logic [KEY_IDX_W-1:0] k_q;

	logic [IDX_W-1:0]     rdv, key_b, i_inc, ks_j, pg_j, t_addr, ks, res;
	logic [2*CFG_W-1:0]   key_all;
	logic [KEY_LEN_W-1:0] len_eff;
	logic                 k_wrap;
	logic                 rd_en, wr_en;
	logic [IDX_W-1:0]     rd_addr, wr_addr, wr_data;

	// entries never written since the last clear read as their own index
	assign rdv     = rd_vld_q ? rd_data_q : rd_addr_q;
	assign key_all = {key_hi_q, key_lo_q};
	assign key_b   = key_all[{k_q, 3'b000} +: IDX_W];
	assign i_inc   = i_q + 8'd1;
	assign ks_j    = mix_q + rdv + key_b;
	assign pg_j    = j_q + rdv;
	assign t_addr  = si_q + rdv;

	always_comb begin
		len_eff = key_len_q;
		if (key_len_q == '0)
			len_eff = KEY_LEN_W'(1);
		else if (key_len_q > KEY_LEN_W'(MAX_KEY_BYTES))
			len_eff = KEY_LEN_W'(MAX_KEY_BYTES);
	end

	assign k_wrap = ({1'b0, k_q} == (len_eff - KEY_LEN_W'(1)));

	// the read of S[t] was issued alongside the write of S[i], so patch in
	// the swapped values where t hits either index
	always_comb begin
		if (rd_addr_q == j_q)
			ks = si_q;
		else if (rd_addr_q == i_q)
			ks = sj_q;
		else
			ks = rdv;
	end

	assign res         = data_q ^ ks;
	assign sts.ks_last = (n_q == '1);
	assign out_byte    = out_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = n_q;
		wr_en   = 1'b0;
		wr_addr = n_q;
		wr_data = rdv;
		unique case (cmd.op)
			OP_NONE: begin
			end
			OP_KS_RD_N: begin
				rd_en = 1'b1;
			end
			OP_KS_RD_J: begin
				rd_en   = 1'b1;
				rd_addr = ks_j;
			end
			OP_KS_WR_N: begin
				wr_en = 1'b1;
			end
			OP_KS_WR_J: begin
				wr_en   = 1'b1;
				wr_addr = mix_q;
				wr_data = si_q;
			end
			OP_PG_RD_I: begin
				rd_en   = 1'b1;
				rd_addr = i_inc;
			end
			OP_PG_RD_J: begin
				rd_en   = 1'b1;
				rd_addr = pg_j;
			end
			OP_PG_WR_I: begin
				rd_en   = 1'b1;
				rd_addr = t_addr;
				wr_en   = 1'b1;
				wr_addr = i_q;
			end
			OP_PG_WR_J: begin
				wr_en   = 1'b1;
				wr_addr = j_q;
				wr_data = si_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
			rd_vld_q  <= vld_q[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.clr_valid) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo_q  <= '0;
			key_hi_q  <= '0;
			key_len_q <= KEY_LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_LO:  key_lo_q  <= cfg_data;
				REG_KEY_HI:  key_hi_q  <= cfg_data;
				REG_KEY_LEN: key_len_q <= cfg_data[KEY_LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q   <= '0;
			j_q   <= '0;
			n_q   <= '0;
			k_q   <= '0;
			mix_q <= '0;
		end else if (cmd.ks_init) begin
			i_q   <= '0;
			j_q   <= '0;
			n_q   <= '0;
			k_q   <= '0;
			mix_q <= '0;
		end else begin
			if (cmd.op == OP_KS_RD_J)
				mix_q <= ks_j;
			if (cmd.op == OP_KS_WR_J) begin
				n_q <= n_q + 8'd1;
				k_q <= k_wrap ? '0 : k_q + KEY_IDX_W'(1);
			end
			if (cmd.op == OP_PG_RD_I)
				i_q <= i_inc;
			if (cmd.op == OP_PG_RD_J)
				j_q <= pg_j;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			data_q <= in_byte;
		if (cmd.op == OP_KS_RD_J || cmd.op == OP_PG_RD_J)
			si_q <= rdv;
		if (cmd.op == OP_PG_WR_I)
			sj_q <= rdv;
		if (cmd.op == OP_PG_WR_J)
			res_q <= res;
		if (cmd.out_load)
			out_q <= cmd.out_hold ? res_q : res;
	end

endmodule

// ----- hw/rtl/rc4_stream_cipher.sv -----
// Each keystream step reads S[i], reads S[j], writes S[i], writes S[j] and loads the output
// register (the result is parked while the output stalls); 3 table reads, 2 writes per step.
// One byte is in flight at a time; a byte with s_axis_tuser set first runs 256 key schedule rounds.
// Reset: both indices zero, table reads as identity through per-entry valid bits (no sweep),
// key words zero, key length 16.
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 byte stream cipher: controller sequencing a shared table datapath.
// ----------------------------------------------------------------------------
module rc4_stream_cipher import rc4_pkg::*; #(
	parameter int MAX_KEY_BYTES = KEY_BYTES_MAX
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,  // [7:0] data_byte
	input  logic                 s_axis_tuser,  // [0] msg_start
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [7:0]           m_axis_tdata,  // [7:0] out_byte
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cmd_t cmd;
	sts_t sts;

	rc4_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_start  (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	rc4_dp #(
		.MAX_KEY_BYTES (MAX_KEY_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_byte   (s_axis_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_byte  (m_axis_tdata)
	);

	// one byte in flight at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while a byte is in flight");

	// plain keystream byte taken on an empty output is offered once the write-j step loads the output
	a_keystream_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tuser && !m_axis_tvalid
		|-> ##4 m_axis_tvalid)
		else $error("keystream result late");

	// apart from reset, the table is only returned to identity by a message start
	a_clear_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_valid |-> s_axis_tvalid && s_axis_tready && s_axis_tuser)
		else $error("table cleared without a message start");

endmodule
